FILE: rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Depth of the request queue between front and back
    localparam int Q_DEPTH = 2;

    // Action codes of an input request
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Control characters and cell constants
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] RESET_COLOR  = 8'h1F;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_PUT       = 3'd0,
        OP_NEWLINE   = 3'd1,
        OP_RETURN    = 3'd2,
        OP_BACKSPACE = 3'd3,
        OP_READ      = 3'd4,
        OP_READ_NONE = 3'd5,
        OP_CLEAR     = 3'd6,
        OP_NOP       = 3'd7
    } op_t;

    // One queued request
    typedef struct packed {
        op_t        op;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } entry_t;

endpackage

FILE: rtl/text_console_writer.sv
// Top level of the text console writer.
// Text-mode console of ROWS x COLUMNS 16-bit cells (attribute over character) with a
// cursor. After reset the block blanks the whole screen and holds s_ready low meanwhile.
// Each request gives exactly one result. Puts that do not scroll, returns, backspaces,
// out-of-range reads and unused actions stream at one per cycle while the result output
// is not stalled; a read also passes through the ST_READ state because the screen memory
// read is registered. A line advance past the bottom row scrolls through the screen
// memory, one cell per cycle, and then blanks the bottom row; a clear blanks every cell
// and moves the cursor home. A request passes through the front-end holding register,
// the queue and the result register. A short queue between the classifying front end
// and the back end keeps requests flowing while a result waits.
// The color register write port is always ready; write it only while the block is idle.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_char_code,
    input  logic [4:0]  s_read_row,
    input  logic [6:0]  s_read_col,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_cell_value,
    output logic [6:0]  m_cursor_col,
    output logic [4:0]  m_cursor_row,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import tcw_pkg::*;

    logic   enable;
    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    entry_t push_entry;
    entry_t pop_entry;

    assign cfg_ready = 1'b1;

    // Accept and classify requests
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .enable      (enable),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_char_code (s_char_code),
        .s_read_row  (s_read_row),
        .s_read_col  (s_read_col),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    // Buffer classified requests
    tcw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .pop_entry  (pop_entry)
    );

    // Carry out requests on the screen
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .ready_for_items (enable),
        .q_valid         (q_valid),
        .q_entry         (pop_entry),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cell_value    (m_cell_value),
        .m_cursor_col    (m_cursor_col),
        .m_cursor_row    (m_cursor_row)
    );

endmodule

FILE: rtl/tcw_front.sv
// Front end: accepts requests, classifies them and feeds the queue.
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            enable,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      s_action,
    input  logic [7:0]      s_char_code,
    input  logic [4:0]      s_read_row,
    input  logic [6:0]      s_read_col,
    input  logic            q_full,
    output logic            q_push,
    output tcw_pkg::entry_t q_entry
);
    import tcw_pkg::*;

    logic   hold_reg;
    logic   hold_next;
    entry_t ent_reg;
    entry_t ent_next;
    logic   accept;
    logic   in_range;

    // Decide whether a read hits the screen
    assign in_range = (32'(s_read_row) < ROWS) && (32'(s_read_col) < COLUMNS);

    // Classify the incoming request
    always_comb begin
        ent_next           = ent_reg;
        ent_next.char_code = s_char_code;
        ent_next.read_row  = s_read_row;
        ent_next.read_col  = s_read_col;
        unique case (s_action)
            ACT_PUT: begin
                priority if (s_char_code == CH_NEWLINE)   ent_next.op = OP_NEWLINE;
                else if (s_char_code == CH_RETURN)        ent_next.op = OP_RETURN;
                else if (s_char_code == CH_BACKSPACE)     ent_next.op = OP_BACKSPACE;
                else                                      ent_next.op = OP_PUT;
            end
            ACT_READ:  ent_next.op = in_range ? OP_READ : OP_READ_NONE;
            ACT_CLEAR: ent_next.op = OP_CLEAR;
            default:   ent_next.op = OP_NOP;
        endcase
    end

    // Hand the held request to the queue when it has room
    assign q_push  = hold_reg && !q_full;
    assign q_entry = ent_reg;
    assign s_ready = enable && (!hold_reg || !q_full);
    assign accept  = s_valid && s_ready;

    always_comb begin
        hold_next = hold_reg;
        if (accept) begin
            hold_next = 1'b1;
        end else if (q_push) begin
            hold_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b0;
        end else begin
            hold_reg <= hold_next;
        end
    end

    // Capture the classified payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            ent_reg <= ent_next;
        end
    end

endmodule

FILE: rtl/tcw_queue.sv
// Short request queue between the front end and the back end.
module tcw_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tcw_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output tcw_pkg::entry_t pop_entry
);
    import tcw_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int NW = $clog2(Q_DEPTH + 1);

    entry_t        slot_reg [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    assign full      = (count_reg == NW'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/tcw_back.sv
// Back end: screen memory, cursor, scroll and clear sequencer, result register.
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    input  logic [7:0]      cfg_data,
    output logic            ready_for_items,
    input  logic            q_valid,
    input  tcw_pkg::entry_t q_entry,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [15:0]     m_cell_value,
    output logic [6:0]      m_cursor_col,
    output logic [4:0]      m_cursor_row
);
    import tcw_pkg::*;

    localparam int TOTAL = ROWS * COLUMNS;
    localparam int NCOPY = (ROWS - 1) * COLUMNS;
    localparam int AW    = $clog2(TOTAL);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_READ   = 5'b00100,
        ST_SCROLL = 5'b01000,
        ST_BLANK  = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          init_reg, init_next;
    logic [7:0]    color_reg;
    logic          m_valid_reg, m_valid_next;
    logic [15:0]   cell_reg;
    logic [6:0]    out_col_reg;
    logic [4:0]    out_row_reg;

    logic [15:0]   mem [TOTAL];
    logic [15:0]   rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic          load_out;
    logic [15:0]   out_cell;
    logic          out_free;
    logic [15:0]   blank;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] req_addr;
    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;

    assign blank     = {color_reg, BLANK_CHAR};
    assign cur_addr  = AW'(32'(row_reg) * COLUMNS + 32'(col_reg));
    assign req_addr  = AW'(32'(q_entry.read_row) * COLUMNS + 32'(q_entry.read_col));
    assign col_inc   = {1'b0, col_reg} + 1'b1;
    assign row_inc   = {1'b0, row_reg} + 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid && out_free;

    assign ready_for_items = !init_reg;
    assign m_valid         = m_valid_reg;
    assign m_cell_value    = cell_reg;
    assign m_cursor_col    = out_col_reg;
    assign m_cursor_row    = out_row_reg;

    // Sequence the operations
    always_comb begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        init_next    = init_reg;
        mem_we       = 1'b0;
        mem_waddr    = scan_reg;
        mem_wdata    = blank;
        mem_re       = 1'b0;
        mem_raddr    = req_addr;
        load_out     = 1'b0;
        out_cell     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    unique case (q_entry.op)
                        OP_PUT, OP_NEWLINE: begin
                            if (q_entry.op == OP_PUT) begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr;
                                mem_wdata = {color_reg, q_entry.char_code};
                            end
                            if (q_entry.op == OP_PUT && col_inc != (CW+1)'(COLUMNS)) begin
                                col_next = CW'(col_inc);
                                load_out = 1'b1;
                            end else begin
                                // Move to the next line, scroll past the bottom
                                col_next = '0;
                                if (row_inc == (RW+1)'(ROWS)) begin
                                    scan_next  = '0;
                                    state_next = ST_SCROLL;
                                end else begin
                                    row_next = RW'(row_inc);
                                    load_out = 1'b1;
                                end
                            end
                        end
                        OP_RETURN: begin
                            col_next = '0;
                            load_out = 1'b1;
                        end
                        OP_BACKSPACE: begin
                            if (col_reg != '0) begin
                                col_next  = col_reg - 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr - 1'b1;
                            end
                            load_out = 1'b1;
                        end
                        OP_READ: begin
                            mem_re     = 1'b1;
                            state_next = ST_READ;
                        end
                        OP_CLEAR: begin
                            col_next   = '0;
                            row_next   = '0;
                            scan_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        OP_READ_NONE, OP_NOP: begin
                            load_out = 1'b1;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                out_cell   = rd_data_reg;
                load_out   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCROLL: begin
                // Write the row data fetched last cycle one row higher
                if (scan_reg != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = scan_reg - 1'b1;
                    mem_wdata = rd_data_reg;
                end
                if (scan_reg == AW'(NCOPY)) begin
                    state_next = ST_BLANK;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'({1'b0, scan_reg} + (AW+1)'(COLUMNS));
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_BLANK: begin
                mem_we = 1'b1;
                if (scan_reg == AW'(TOTAL - 1)) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (scan_reg == AW'(TOTAL - 1)) begin
                    load_out   = !init_reg;
                    init_next  = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until taken, load a new one when produced
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (load_out) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            scan_reg    <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            init_reg    <= 1'b1;
            color_reg   <= RESET_COLOR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            scan_reg    <= scan_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            init_reg    <= init_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                color_reg <= cfg_data;
            end
        end
    end

    // Capture the result payload
    always_ff @(posedge aclk) begin
        if (load_out) begin
            cell_reg    <= out_cell;
            out_col_reg <= 7'(col_next);
            out_row_reg <= 5'(row_next);
        end
    end

    // Screen memory: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule
